// File: hdl/tth_pkg.sv
// ============================================================================
// tth_pkg: time tag histogram shared definitions
// Field widths, action and register codes, configuration record.
// ============================================================================
`default_nettype none

package tth_pkg;

    localparam int MAX_BINS_DEF   = 1024;
    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 32;

    localparam int ACTION_W    = 2;
    localparam int TS_W        = 48;
    localparam int CH_W        = 3;
    localparam int SWEEP_W     = 16;
    localparam int RBIN_W      = 10;
    localparam int COUNT_OUT_W = 32;
    localparam int WIDTH_W     = 48;
    localparam int NBINS_W     = 11;
    localparam int CHMASK_W    = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [ACTION_W-1:0] ACT_COUNT      = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ       = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_FILTER_ON = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_SELECT    = 3'd5;

    typedef struct packed {
        logic [TS_W-1:0]     window_start;
        logic [WIDTH_W-1:0]  bin_width;
        logic [NBINS_W-1:0]  bins_in_use;
        logic [CHMASK_W-1:0] channel_mask;
        logic                sweep_filter_on;
        logic [SWEEP_W-1:0]  sweep_select;
    } tth_cfg_t;

endpackage

`default_nettype wire

// File: hdl/tth_stream_if.sv
// ============================================================================
// tth stream interfaces
// Valid/ready channels for incoming requests and outgoing results.
// ============================================================================
`default_nettype none

interface tth_event_if;
    logic                          valid;
    logic                          ready;
    logic [tth_pkg::ACTION_W-1:0]  action;
    logic [tth_pkg::TS_W-1:0]      timestamp;
    logic [tth_pkg::CH_W-1:0]      channel;
    logic [tth_pkg::SWEEP_W-1:0]   sweep;
    logic [tth_pkg::RBIN_W-1:0]    read_bin;

    modport source (output valid, action, timestamp, channel, sweep, read_bin, input ready);
    modport sink   (input valid, action, timestamp, channel, sweep, read_bin, output ready);
endinterface

interface tth_result_if;
    logic                             valid;
    logic                             ready;
    logic                             counted;
    logic [tth_pkg::RBIN_W-1:0]       bin_index;
    logic [tth_pkg::COUNT_OUT_W-1:0]  bin_count;
    logic                             saturated;

    modport source (output valid, counted, bin_index, bin_count, saturated, input ready);
    modport sink   (input valid, counted, bin_index, bin_count, saturated, output ready);
endinterface

`default_nettype wire

// File: hdl/time_tag_histogram_core.sv
// ============================================================================
// time_tag_histogram_core: time-binned event histogram
// Count request: window check, bin divide, counter read-modify-write, result register;
// the divider yields one quotient bit per cycle. Reads skip check and divide, drops
// skip divide and update. One request at a time: the next is taken once the result is
// loaded for output. Reset: counters cleared bin by bin, no request accepted meanwhile.
// ============================================================================
`default_nettype none

module time_tag_histogram_core #(
    parameter int MAX_BINS   = tth_pkg::MAX_BINS_DEF,
    parameter int TIME_BITS  = tth_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = tth_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tth_event_if.sink                       item,
    tth_result_if.source                    result,
    input  logic                            cfg_we,
    input  logic [tth_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tth_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int BIN_BITS = $clog2(MAX_BINS);
    localparam int NB       = $clog2(MAX_BINS + 1);
    localparam int NBW      = (NB > tth_pkg::NBINS_W) ? NB : tth_pkg::NBINS_W;
    localparam int DW       = (TIME_BITS < tth_pkg::TS_W) ? TIME_BITS : tth_pkg::TS_W;
    localparam int LW       = tth_pkg::WIDTH_W + NB;
    localparam int RBW      = (NB > tth_pkg::RBIN_W) ? NB : tth_pkg::RBIN_W;
    localparam int QXW      = (BIN_BITS > tth_pkg::RBIN_W) ? BIN_BITS : tth_pkg::RBIN_W;
    localparam int CXW      = (COUNT_BITS > tth_pkg::COUNT_OUT_W) ? COUNT_BITS
                                                                   : tth_pkg::COUNT_OUT_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_RMW   = 3'd4;
    localparam logic [2:0] ST_PUT   = 3'd5;

    tth_pkg::tth_cfg_t cfg;

    logic [2:0]          state_reg, state_next;
    logic [BIN_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                out_valid_reg, out_valid_next;

    logic [tth_pkg::ACTION_W-1:0] act_reg;
    logic [DW-1:0]                diff_reg;
    logic [LW-1:0]                limit_reg;
    logic                         pass_reg;
    logic [tth_pkg::RBIN_W-1:0]   idx_reg;
    logic [BIN_BITS-1:0]          addr_reg;
    logic                         res_counted_reg;
    logic [tth_pkg::RBIN_W-1:0]   res_idx_reg;
    logic [COUNT_BITS-1:0]        res_cnt_reg;
    logic                         out_counted_reg;
    logic [tth_pkg::RBIN_W-1:0]   out_idx_reg;
    logic [tth_pkg::COUNT_OUT_W-1:0] out_cnt_reg;
    logic                         out_sat_reg;

    logic                accept;
    logic                out_free;
    logic [NBW-1:0]      bins_ext;
    logic [NBW-1:0]      nbins_full;
    logic [NB-1:0]       nbins;
    logic [LW-1:0]       limit_comb;
    logic [DW:0]         diff_comb;
    logic                filt_ok;
    logic [RBW-1:0]      rb_ext;
    logic                rb_in;
    logic                is_read;

    logic                div_start;
    logic                div_done;
    logic [BIN_BITS-1:0] quot;
    logic [QXW-1:0]      quot_ext;

    logic                mem_we;
    logic [BIN_BITS-1:0] mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [BIN_BITS-1:0] mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;
    logic                at_max;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [CXW-1:0]      cnt_ext;

    tth_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    tth_bin_div #(
        .DW (DW),
        .QW (BIN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg),
        .divisor  (cfg.bin_width),
        .done     (div_done),
        .quotient (quot)
    );

    tth_count_ram #(
        .DEPTH (MAX_BINS),
        .AW    (BIN_BITS),
        .DW    (COUNT_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // window end = bins in use times bin width; zero width or zero bins drop all
    assign bins_ext   = NBW'(cfg.bins_in_use);
    assign nbins_full = (bins_ext > NBW'(MAX_BINS)) ? NBW'(MAX_BINS) : bins_ext;
    assign nbins      = nbins_full[NB-1:0];
    assign limit_comb = LW'(nbins) * LW'(cfg.bin_width);

    assign diff_comb = {1'b0, item.timestamp[DW-1:0]} - {1'b0, cfg.window_start[DW-1:0]};
    assign filt_ok   = cfg.channel_mask[item.channel]
                       && (!cfg.sweep_filter_on || (item.sweep == cfg.sweep_select));

    assign rb_ext  = RBW'(item.read_bin);
    assign rb_in   = (rb_ext < RBW'(MAX_BINS));
    assign is_read = (item.action == tth_pkg::ACT_READ)
                     || (item.action == tth_pkg::ACT_READ_CLEAR);

    assign quot_ext = QXW'(quot);

    assign div_start = (state_reg == ST_CHECK) && pass_reg && (LW'(diff_reg) < limit_reg);

    assign at_max  = (mem_rdata == {COUNT_BITS{1'b1}});
    assign cnt_inc = at_max ? mem_rdata : mem_rdata + COUNT_BITS'(1);
    assign cnt_ext = CXW'(res_cnt_reg);

    // memory ports: one request in flight, so a read never meets a pending write
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = quot;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = cnt_inc;
        if (state_reg == ST_IDLE)
        begin
            mem_re    = accept && is_read && rb_in;
            mem_raddr = rb_ext[BIN_BITS-1:0];
        end
        else if (state_reg == ST_DIV)
        begin
            mem_re = div_done;
        end
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_RMW)
        begin
            if (act_reg == tth_pkg::ACT_COUNT)
            begin
                mem_we = 1'b1;
            end
            else if (act_reg == tth_pkg::ACT_READ_CLEAR)
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + BIN_BITS'(1);
                if (clr_addr_reg == BIN_BITS'(MAX_BINS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.action == tth_pkg::ACT_COUNT)
                        state_next = ST_CHECK;
                    else if (is_read && rb_in)
                        state_next = ST_RMW;
                    else
                        state_next = ST_PUT;
                end
            end
            ST_CHECK:
            begin
                state_next = div_start ? ST_DIV : ST_PUT;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_RMW;
            end
            ST_RMW:
            begin
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= item.action;
            diff_reg  <= diff_comb[DW-1:0];
            limit_reg <= limit_comb;
            pass_reg  <= filt_ok && !diff_comb[DW];
            idx_reg   <= item.read_bin;
            res_counted_reg <= 1'b0;
            res_cnt_reg     <= '0;
            // reads echo the requested bin; drops and unused codes return zero
            res_idx_reg     <= is_read ? item.read_bin : '0;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            addr_reg <= quot;
            idx_reg  <= quot_ext[tth_pkg::RBIN_W-1:0];
        end
        if (state_reg == ST_RMW)
        begin
            res_idx_reg <= idx_reg;
            if (act_reg == tth_pkg::ACT_COUNT)
            begin
                res_counted_reg <= 1'b1;
                res_cnt_reg     <= cnt_inc;
            end
            else
            begin
                res_cnt_reg <= mem_rdata;
            end
        end
        if (state_reg == ST_IDLE && accept && is_read)
            addr_reg <= rb_ext[BIN_BITS-1:0];
        if (state_reg == ST_PUT && out_free)
        begin
            out_counted_reg <= res_counted_reg;
            out_idx_reg     <= res_idx_reg;
            out_cnt_reg     <= cnt_ext[tth_pkg::COUNT_OUT_W-1:0];
            out_sat_reg     <= (res_cnt_reg == {COUNT_BITS{1'b1}});
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.counted   = out_counted_reg;
    assign result.bin_index = out_idx_reg;
    assign result.bin_count = out_cnt_reg;
    assign result.saturated = out_sat_reg;

endmodule

`default_nettype wire

// File: hdl/tth_cfg_regs.sv
// ============================================================================
// tth_cfg_regs: configuration register file
// Write-only registers loaded by index from the configuration port.
// ============================================================================
`default_nettype none

module tth_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [tth_pkg::CFG_IDX_W-1:0]    index,
    input  logic [tth_pkg::CFG_DATA_W-1:0]   wdata,
    output tth_pkg::tth_cfg_t                cfg
);

    tth_pkg::tth_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_start    <= '0;
            cfg_reg.bin_width       <= tth_pkg::WIDTH_W'(1);
            cfg_reg.bins_in_use     <= tth_pkg::NBINS_W'(1024);
            cfg_reg.channel_mask    <= '1;
            cfg_reg.sweep_filter_on <= 1'b0;
            cfg_reg.sweep_select    <= '0;
        end
        else if (we)
        begin
            unique case (index)
                tth_pkg::CFG_WINDOW_START:
                    cfg_reg.window_start <= wdata[tth_pkg::TS_W-1:0];
                tth_pkg::CFG_BIN_WIDTH:
                    cfg_reg.bin_width <= wdata[tth_pkg::WIDTH_W-1:0];
                tth_pkg::CFG_BINS_IN_USE:
                    cfg_reg.bins_in_use <= wdata[tth_pkg::NBINS_W-1:0];
                tth_pkg::CFG_CHANNEL_MASK:
                    cfg_reg.channel_mask <= wdata[tth_pkg::CHMASK_W-1:0];
                tth_pkg::CFG_SWEEP_FILTER_ON:
                    cfg_reg.sweep_filter_on <= wdata[0];
                tth_pkg::CFG_SWEEP_SELECT:
                    cfg_reg.sweep_select <= wdata[tth_pkg::SWEEP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/tth_bin_div.sv
// ============================================================================
// tth_bin_div: bin number divider
// Restoring division, one quotient bit per cycle, for a quotient of QW bits.
// ============================================================================
`default_nettype none

module tth_bin_div #(
    parameter int DW = 48,
    parameter int QW = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DW-1:0]                  dividend,
    input  logic [tth_pkg::WIDTH_W-1:0]    divisor,
    output logic                           done,
    output logic [QW-1:0]                  quotient
);

    localparam int RW = tth_pkg::WIDTH_W + QW;
    localparam int SW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [SW-1:0] step_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] dsh_reg;
    logic [QW-1:0] quo_reg;
    logic          ge;

    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + SW'(1);
            if (step_reg == SW'(QW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend stays below divisor * 2**QW, so QW steps finish the quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= RW'(dividend);
            dsh_reg <= RW'(divisor) << (QW - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= QW'({quo_reg, ge});
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/tth_count_ram.sv
// ============================================================================
// tth_count_ram: bin counter memory
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module tth_count_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: bench/time_tag_histogram_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// time_tag_histogram_core_tb: self-checking bench for the time tag histogram
// Drives count, read and read-and-clear requests under random handshake gaps,
// keeps a shadow histogram with its own copy of the registers, and compares
// every result field by field against the tally predicted at acceptance.
// ============================================================================

module time_tag_histogram_core_tb;

    import tth_pkg::*;

    localparam int MAX_BINS         = MAX_BINS_DEF;
    localparam int STALL_LIMIT      = 4000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PHASES    = 8;
    localparam int RANDOM_PER_PHASE = 175;
    localparam int REPORT_LIMIT     = 10;

    localparam logic [ACTION_W-1:0]    ACT_UNUSED = 2'd3;
    localparam logic [TS_W-1:0]        TS_MAX     = '1;
    localparam logic [COUNT_OUT_W-1:0] COUNT_MAX  = '1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [TS_W-1:0]     timestamp;
        logic [CH_W-1:0]     channel;
        logic [SWEEP_W-1:0]  sweep;
        logic [RBIN_W-1:0]   read_bin;
    } request_t;

    typedef struct packed {
        logic                   counted;
        logic [RBIN_W-1:0]      bin_index;
        logic [COUNT_OUT_W-1:0] bin_count;
        logic                   saturated;
    } bin_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tth_event_if  req_ch ();
    tth_result_if res_ch ();

    time_tag_histogram_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow histogram and registers
    logic [COUNT_OUT_W-1:0] bin_tally [MAX_BINS];
    tth_cfg_t               active_setup;
    bin_result_t            outcomes_due [$];

    int          mismatch_count;
    int          quiet_cycles;
    bit          steady_sender;
    bin_result_t got_result;
    bin_result_t due_result;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [TS_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[TS_W-1:0];
    endfunction

    // mostly zero, some short, a few long
    function automatic int idle_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic request_t make_req(input logic [ACTION_W-1:0] action,
                                          input logic [TS_W-1:0]     ts,
                                          input logic [CH_W-1:0]     ch,
                                          input logic [SWEEP_W-1:0]  sw,
                                          input logic [RBIN_W-1:0]   rb);
        request_t r;
        r.action    = action;
        r.timestamp = ts;
        r.channel   = ch;
        r.sweep     = sw;
        r.read_bin  = rb;
        return r;
    endfunction

    function automatic tth_cfg_t make_setup(input logic [TS_W-1:0]     ws,
                                            input logic [WIDTH_W-1:0]  bw,
                                            input logic [NBINS_W-1:0]  nb,
                                            input logic [CHMASK_W-1:0] mask,
                                            input logic                filt,
                                            input logic [SWEEP_W-1:0]  sel);
        tth_cfg_t c;
        c.window_start    = ws;
        c.bin_width       = bw;
        c.bins_in_use     = nb;
        c.channel_mask    = mask;
        c.sweep_filter_on = filt;
        c.sweep_select    = sel;
        return c;
    endfunction

    function automatic int effective_bins();
        return (active_setup.bins_in_use > MAX_BINS) ? MAX_BINS : active_setup.bins_in_use;
    endfunction

    // apply one request to the shadow histogram and return its result
    function automatic bin_result_t histogram_outcome(input request_t r);
        bin_result_t     o;
        int              nbins;
        logic [TS_W-1:0] bin;
        logic            keep;
        o = '0;
        case (r.action)
            ACT_COUNT:
            begin
                nbins = effective_bins();
                keep = active_setup.channel_mask[r.channel]
                       && !(active_setup.sweep_filter_on && r.sweep != active_setup.sweep_select)
                       && active_setup.bin_width != '0 && nbins != 0
                       && r.timestamp >= active_setup.window_start;
                if (keep)
                begin
                    bin = (r.timestamp - active_setup.window_start) / active_setup.bin_width;
                    if (bin < TS_W'(nbins))
                    begin
                        if (bin_tally[bin[RBIN_W-1:0]] != COUNT_MAX)
                            bin_tally[bin[RBIN_W-1:0]]++;
                        o.counted   = 1'b1;
                        o.bin_index = bin[RBIN_W-1:0];
                        o.bin_count = bin_tally[bin[RBIN_W-1:0]];
                        o.saturated = (o.bin_count == COUNT_MAX);
                    end
                end
            end
            ACT_READ, ACT_READ_CLEAR:
            begin
                o.bin_index = r.read_bin;
                o.bin_count = bin_tally[r.read_bin];
                o.saturated = (o.bin_count == COUNT_MAX);
                if (r.action == ACT_READ_CLEAR)
                    bin_tally[r.read_bin] = '0;
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    task automatic note_mismatch(input string why, input bin_result_t want,
                                 input bin_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $write("%0t %s: expected counted=%0b bin=%0d count=%0d sat=%0b, ",
                   $realtime, why, want.counted, want.bin_index, want.bin_count,
                   want.saturated);
            $display("got counted=%0b bin=%0d count=%0d sat=%0b",
                     got.counted, got.bin_index, got.bin_count, got.saturated);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
        begin
            got_result.counted   = res_ch.counted;
            got_result.bin_index = res_ch.bin_index;
            got_result.bin_count = res_ch.bin_count;
            got_result.saturated = res_ch.saturated;
            if (outcomes_due.size() == 0)
            begin
                note_mismatch("result with no pending request", '0, got_result);
            end
            else
            begin
                due_result = outcomes_due.pop_front();
                if (got_result.counted !== due_result.counted
                    || got_result.bin_index !== due_result.bin_index
                    || got_result.bin_count !== due_result.bin_count
                    || got_result.saturated !== due_result.saturated)
                    note_mismatch("result mismatch", due_result, got_result);
            end
        end
    end

    // watchdog: count cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("time_tag_histogram_core verification failed");
            $finish;
        end
    end

    // result sink: ready runs with random stalls
    initial
    begin
        int span;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            span = idle_span();
            if (span > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input request_t r);
        int gap;
        gap = steady_sender ? 0 : idle_span();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.action    <= r.action;
        req_ch.timestamp <= r.timestamp;
        req_ch.channel   <= r.channel;
        req_ch.sweep     <= r.sweep;
        req_ch.read_bin  <= r.read_bin;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        outcomes_due.push_back(histogram_outcome(r));
    endtask

    // drop valid and wait for the histogram to drain
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_setup(input tth_cfg_t c);
        write_reg(CFG_WINDOW_START, c.window_start);
        write_reg(CFG_BIN_WIDTH, c.bin_width);
        write_reg(CFG_BINS_IN_USE, CFG_DATA_W'(c.bins_in_use));
        write_reg(CFG_CHANNEL_MASK, CFG_DATA_W'(c.channel_mask));
        write_reg(CFG_SWEEP_FILTER_ON, CFG_DATA_W'(c.sweep_filter_on));
        write_reg(CFG_SWEEP_SELECT, CFG_DATA_W'(c.sweep_select));
        cfg_we <= 1'b0;
        active_setup = c;
    endtask

    function automatic tth_cfg_t pick_setup();
        tth_cfg_t c;
        case ($urandom_range(0, 3))
            0:       c.window_start = '0;
            1:       c.window_start = rand48();
            default: c.window_start = TS_W'($urandom_range(0, 100000));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c.bin_width = WIDTH_W'($urandom_range(1, 8));
            5, 6, 7:       c.bin_width = WIDTH_W'($urandom_range(1, 1 << 20));
            8:             c.bin_width = rand48() | WIDTH_W'(1);
            default:       c.bin_width = WIDTH_W'(1);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c.bins_in_use = NBINS_W'($urandom_range(1, 8));
            4, 5, 6:    c.bins_in_use = NBINS_W'($urandom_range(1, 2047));
            default:    c.bins_in_use = NBINS_W'(MAX_BINS);
        endcase
        c.channel_mask    = ($urandom_range(0, 1) == 0) ? CHMASK_W'($urandom_range(0, 255))
                                                        : 8'hFF;
        c.sweep_filter_on = ($urandom_range(0, 2) == 0);
        c.sweep_select    = SWEEP_W'($urandom_range(0, 65535));
        return c;
    endfunction

    // mostly events aimed into the window, with reads and a little noise
    function automatic request_t pick_request();
        request_t         r;
        int               nbins;
        int               roll;
        logic [TS_W-1:0]  offset;
        logic [TS_W-1:0]  ws;
        logic [TS_W-1:0]  bw;
        ws = active_setup.window_start;
        bw = active_setup.bin_width;
        nbins = effective_bins();
        if (nbins == 0)
            nbins = 1;
        r = make_req(ACT_COUNT, rand48(), CH_W'($urandom_range(0, 7)),
                     SWEEP_W'($urandom_range(0, 65535)), RBIN_W'($urandom_range(0, 1023)));
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            if (active_setup.sweep_filter_on && $urandom_range(0, 3) != 0)
                r.sweep = active_setup.sweep_select;
            roll = $urandom_range(0, 9);
            if (roll < 7 && bw != '0)
            begin
                case ($urandom_range(0, 3))
                    0:       offset = '0;
                    1:       offset = bw - 1;
                    default: offset = rand48() % bw;
                endcase
                r.timestamp = ws + TS_W'($urandom_range(0, nbins - 1)) * bw + offset;
            end
            else if (roll == 7)
                r.timestamp = ws - 1;
            else if (roll == 8)
                r.timestamp = ws + TS_W'(nbins) * bw;
        end
        else
        begin
            if (roll < 80)
                r.action = ACT_READ;
            else if (roll < 95)
                r.action = ACT_READ_CLEAR;
            else
                r.action = ACT_UNUSED;
            if ($urandom_range(0, 9) < 7)
                r.read_bin = RBIN_W'($urandom_range(0, nbins - 1));
        end
        return r;
    endfunction

    // reset register values, bin edges at full resolution, read and clear
    task automatic test_reset_defaults();
        send_request(make_req(ACT_COUNT, '0, 3'd0, 16'd0, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1023, 3'd7, 16'hFFFF, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1024, 3'd2, 16'd0, 10'd0));
        send_request(make_req(ACT_COUNT, TS_MAX, 3'd7, 16'hFFFF, 10'h3FF));
        send_request(make_req(ACT_READ, '0, 3'd0, 16'd0, 10'd0));
        send_request(make_req(ACT_READ_CLEAR, '0, 3'd0, 16'd0, 10'd0));
        send_request(make_req(ACT_READ, '0, 3'd0, 16'd0, 10'd0));
        send_request(make_req(ACT_READ_CLEAR, TS_MAX, 3'd7, 16'hFFFF, 10'h3FF));
        send_request(make_req(ACT_UNUSED, TS_MAX, 3'd7, 16'hFFFF, 10'h3FF));
        settle();
    endtask

    // window start and end, boundary hit, channel mask and sweep filter
    task automatic test_window_filters();
        apply_setup(make_setup(48'd1000, 48'd10, 11'd4, 8'b1000_0101, 1'b1, 16'h1234));
        send_request(make_req(ACT_COUNT, 48'd999, 3'd0, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1000, 3'd0, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1010, 3'd2, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1039, 3'd7, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1040, 3'd0, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1005, 3'd1, 16'h1234, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1005, 3'd0, 16'h1235, 10'd0));
        send_request(make_req(ACT_READ, '0, 3'd0, 16'd0, 10'd1));
        settle();
        apply_setup(make_setup(48'd1000, 48'd10, 11'd4, 8'h00, 1'b0, 16'h0000));
        send_request(make_req(ACT_COUNT, 48'd1005, 3'd0, 16'h1234, 10'd0));
        settle();
    endtask

    // zero width, zero bins, oversized bin count, registers at their maximum
    task automatic test_degenerate_setups();
        apply_setup(make_setup('0, '0, 11'd1024, 8'hFF, 1'b0, 16'hFFFF));
        send_request(make_req(ACT_COUNT, 48'd5, 3'd1, 16'd0, 10'd0));
        settle();
        apply_setup(make_setup('0, 48'd1, 11'd0, 8'hFF, 1'b0, 16'd0));
        send_request(make_req(ACT_COUNT, '0, 3'd0, 16'd0, 10'd0));
        settle();
        apply_setup(make_setup('0, 48'd1, 11'h7FF, 8'hFF, 1'b0, 16'd0));
        send_request(make_req(ACT_COUNT, 48'd1023, 3'd4, 16'd0, 10'd0));
        send_request(make_req(ACT_COUNT, 48'd1024, 3'd4, 16'd0, 10'd0));
        settle();
        apply_setup(make_setup(TS_MAX, TS_MAX, 11'd1, 8'hFF, 1'b1, 16'hFFFF));
        send_request(make_req(ACT_COUNT, TS_MAX, 3'd7, 16'hFFFF, 10'd0));
        send_request(make_req(ACT_COUNT, TS_MAX - 1, 3'd7, 16'hFFFF, 10'd0));
        settle();
        apply_setup(make_setup('0, TS_MAX, 11'd2, 8'hFF, 1'b0, 16'd0));
        send_request(make_req(ACT_COUNT, TS_MAX, 3'd3, 16'd0, 10'd0));
        settle();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_setup(pick_setup());
            // hold valid back-to-back on every third phase
            steady_sender = (phase % 3 == 0);
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(pick_request());
            settle();
        end
        steady_sender = 1'b0;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.action    <= '0;
        req_ch.timestamp <= '0;
        req_ch.channel   <= '0;
        req_ch.sweep     <= '0;
        req_ch.read_bin  <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        mismatch_count   = 0;
        quiet_cycles     = 0;
        steady_sender    = 1'b0;
        for (int i = 0; i < MAX_BINS; i++)
            bin_tally[i] = '0;
        active_setup = make_setup('0, 48'd1, 11'd1024, 8'hFF, 1'b0, 16'd0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_window_filters();
        test_degenerate_setups();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outcomes_due.size() == 0)
            $display("time_tag_histogram_core verification clean");
        else
            $display("time_tag_histogram_core verification failed");
        $finish;
    end

endmodule
